// ----- rtl/spra_pkg.sv -----
// Shared types and codes for the slotted page record allocator.
// No dependencies.
package spra_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] record_bytes;
      logic [30:0] record_key;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [3:0] page_index;
      logic [5:0] slot_index;
      logic [6:0] count_value;
      logic       last_result;
   } rsp_type;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_STATUS = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   localparam logic [2:0] KIND_PAGE_TOTAL = 3'd0;
   localparam logic [2:0] KIND_PAGE_COUNT = 3'd1;
   localparam logic [2:0] KIND_HIT        = 3'd2;
   localparam logic [2:0] KIND_MISS       = 3'd3;
   localparam logic [2:0] KIND_FULL       = 3'd4;

   localparam logic [15:0] HEADER_BYTES  = 16'd16;
   localparam logic [15:0] SLOT_OVERHEAD = 16'd4;
   localparam logic [15:0] PAGE_BYTES_RESET = 16'd4096;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_INS_NEW,
      ST_ERR,
      ST_STAT_TOT,
      ST_STAT_RD,
      ST_STAT_EMIT,
      ST_SRCH_PRD,
      ST_SRCH_PCHK,
      ST_SRCH_KRD,
      ST_SRCH_KCHK,
      ST_SRCH_PUSH,
      ST_SRCH_END
   } state_type;

endpackage

// ----- rtl/spra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/slotted_page_record_allocator.sv -----
// Slotted page record allocator top level. Uses spra_pkg and spra_ram.
// Page table and key store live in two RAMs; a sequencer walks them.
//
// One transaction is handled at a time. Each page or key access is split
// into an address state and a check of the registered read data: insert
// reads the open pages in turn until one fits; status emits the page total,
// then reads and reports each open page; search reads each open page and
// compares its keys in turn until the first match in that page. Results
// go out through a single output register, so a stalled rsp_ready holds the
// sequencer at the next result. The key RAM and page RAM read port set the
// pace. Stores need no clearing pass: entries are read only once written.
module slotted_page_record_allocator #(
   parameter int MAX_PAGES = 16,
   parameter int MAX_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spra_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import spra_pkg::*;

   localparam int PW  = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
   localparam int SW  = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
   localparam int OW  = $clog2(MAX_PAGES + 1);
   localparam int CW  = $clog2(MAX_SLOTS + 1);
   localparam int KD  = MAX_PAGES * MAX_SLOTS;
   localparam int KAW = KD > 1 ? $clog2(KD) : 1;
   localparam int PGW = 16 + CW;

   // registers
   state_type        state_ff, state_in;
   logic [15:0]      page_bytes_ff;
   logic [OW-1:0]    pages_open_ff, pages_open_in;
   req_type          item_ff, item_in;
   logic [PW-1:0]    page_ff, page_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    limit_ff, limit_in;
   logic             hit_ff, hit_in;
   logic [PW-1:0]    hit_page_ff, hit_page_in;
   logic [SW-1:0]    hit_slot_ff, hit_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // RAM ports
   logic             pg_we, pg_re, key_we, key_re;
   logic [PW-1:0]    pg_waddr, pg_raddr;
   logic [PGW-1:0]   pg_wdata, pg_rdata;
   logic [KAW-1:0]   key_waddr, key_raddr;
   logic [30:0]      key_rdata;

   // datapath
   logic [15:0]      used_rd;
   logic [CW-1:0]    count_rd, count_lim;
   logic [16:0]      need;
   logic [17:0]      grown, fresh;
   logic [15:0]      grown_sat, fresh_sat;
   logic             fits, last_page, last_slot;
   logic             emit, load;
   rsp_type          emit_data;
   logic [31:0]      page_wide, hpage_wide, hslot_wide, open_wide, cnt_wide;

   function automatic logic [KAW-1:0] key_addr(input logic [PW-1:0] p,
                                                input logic [SW-1:0] s);
      key_addr = KAW'(KAW'(p) * KAW'(MAX_SLOTS) + KAW'(s));
   endfunction

   spra_ram #(.WIDTH(PGW), .DEPTH(MAX_PAGES)) u_page_ram (
      .clock  (clock),
      .wr_en  (pg_we),
      .wr_addr(pg_waddr),
      .wr_data(pg_wdata),
      .rd_en  (pg_re),
      .rd_addr(pg_raddr),
      .rd_data(pg_rdata)
   );

   spra_ram #(.WIDTH(31), .DEPTH(KD)) u_key_ram (
      .clock  (clock),
      .wr_en  (key_we),
      .wr_addr(key_waddr),
      .wr_data(item_ff.record_key),
      .rd_en  (key_re),
      .rd_addr(key_raddr),
      .rd_data(key_rdata)
   );

   assign used_rd   = pg_rdata[PGW-1:CW];
   assign count_rd  = pg_rdata[CW-1:0];
   assign count_lim = (count_rd > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : count_rd;
   assign need      = {1'b0, item_ff.record_bytes} + {1'b0, SLOT_OVERHEAD};
   assign grown     = {2'b00, used_rd} + {1'b0, need};
   assign fresh     = {2'b00, HEADER_BYTES} + {1'b0, need};
   assign grown_sat = grown > 18'd65535 ? 16'hFFFF : grown[15:0];
   assign fresh_sat = fresh > 18'd65535 ? 16'hFFFF : fresh[15:0];
   // signed free space >= need reduces to capacity >= used + need
   assign fits      = {2'b00, page_bytes_ff} >= grown;
   assign last_page = (OW'(page_ff) + OW'(1)) == pages_open_ff;
   assign last_slot = (CW'(slot_ff) + CW'(1)) == limit_ff;

   assign page_wide  = 32'(page_ff);
   assign hpage_wide = 32'(hit_page_ff);
   assign hslot_wide = 32'(hit_slot_ff);
   assign open_wide  = 32'(pages_open_ff);
   assign cnt_wide   = 32'(count_rd);

   // output register accepts a new result when empty or draining
   assign load = emit && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.action)
                  ACT_INSERT: state_in = (pages_open_ff == '0) ? ST_INS_NEW : ST_INS_RD;
                  ACT_STATUS: state_in = ST_STAT_TOT;
                  ACT_SEARCH: state_in = (pages_open_ff == '0) ? ST_SRCH_END : ST_SRCH_PRD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_RD:  state_in = ST_INS_CHK;
         ST_INS_CHK: begin
            if (fits) begin
               state_in = (count_rd >= CW'(MAX_SLOTS)) ? ST_ERR : ST_IDLE;
            end else begin
               state_in = last_page ? ST_INS_NEW : ST_INS_RD;
            end
         end
         ST_INS_NEW: state_in = (pages_open_ff >= OW'(MAX_PAGES)) ? ST_ERR : ST_IDLE;
         ST_ERR:     state_in = load ? ST_IDLE : ST_ERR;
         ST_STAT_TOT: begin
            if (load) begin
               state_in = (pages_open_ff == '0) ? ST_IDLE : ST_STAT_RD;
            end
         end
         ST_STAT_RD: state_in = ST_STAT_EMIT;
         ST_STAT_EMIT: begin
            if (load) begin
               state_in = last_page ? ST_IDLE : ST_STAT_RD;
            end
         end
         ST_SRCH_PRD: state_in = ST_SRCH_PCHK;
         ST_SRCH_PCHK: begin
            if (count_lim != '0) begin
               state_in = ST_SRCH_KRD;
            end else begin
               state_in = last_page ? ST_SRCH_END : ST_SRCH_PRD;
            end
         end
         ST_SRCH_KRD: state_in = ST_SRCH_KCHK;
         ST_SRCH_KCHK: begin
            if (key_rdata == item_ff.record_key) begin
               if (hit_ff) begin
                  state_in = ST_SRCH_PUSH;
               end else begin
                  state_in = last_page ? ST_SRCH_END : ST_SRCH_PRD;
               end
            end else if (last_slot) begin
               state_in = last_page ? ST_SRCH_END : ST_SRCH_PRD;
            end else begin
               state_in = ST_SRCH_KRD;
            end
         end
         ST_SRCH_PUSH: begin
            if (load) begin
               state_in = last_page ? ST_SRCH_END : ST_SRCH_PRD;
            end
         end
         ST_SRCH_END: state_in = load ? ST_IDLE : ST_SRCH_END;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      item_in       = item_ff;
      page_in       = page_ff;
      slot_in       = slot_ff;
      limit_in      = limit_ff;
      hit_in        = hit_ff;
      hit_page_in   = hit_page_ff;
      hit_slot_in   = hit_slot_ff;
      pages_open_in = pages_open_ff;
      pg_we         = 1'b0;
      pg_waddr      = page_ff;
      pg_wdata      = {grown_sat, CW'(count_rd + CW'(1))};
      pg_re         = 1'b0;
      pg_raddr      = page_ff;
      key_we        = 1'b0;
      key_waddr     = key_addr(page_ff, SW'(count_rd));
      key_re        = 1'b0;
      key_raddr     = key_addr(page_ff, slot_ff);
      emit          = 1'b0;
      emit_data     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               page_in = '0;
               hit_in  = 1'b0;
            end
         end
         ST_INS_RD: pg_re = 1'b1;
         ST_INS_CHK: begin
            if (fits) begin
               if (count_rd < CW'(MAX_SLOTS)) begin
                  pg_we  = 1'b1;
                  key_we = 1'b1;
               end
            end else begin
               page_in = PW'(page_ff + PW'(1));
            end
         end
         ST_INS_NEW: begin
            if (pages_open_ff < OW'(MAX_PAGES)) begin
               pg_we         = 1'b1;
               pg_waddr      = PW'(pages_open_ff);
               pg_wdata      = {fresh_sat, CW'(1)};
               key_we        = 1'b1;
               key_waddr     = key_addr(PW'(pages_open_ff), '0);
               pages_open_in = OW'(pages_open_ff + OW'(1));
            end
         end
         ST_ERR: begin
            emit                  = 1'b1;
            emit_data.result_kind = KIND_FULL;
            emit_data.last_result = 1'b1;
         end
         ST_STAT_TOT: begin
            emit                  = 1'b1;
            emit_data.result_kind = KIND_PAGE_TOTAL;
            emit_data.count_value = open_wide[6:0];
            emit_data.last_result = (pages_open_ff == '0);
         end
         ST_STAT_RD: pg_re = 1'b1;
         ST_STAT_EMIT: begin
            emit                  = 1'b1;
            emit_data.result_kind = KIND_PAGE_COUNT;
            emit_data.page_index  = page_wide[3:0];
            emit_data.count_value = cnt_wide[6:0];
            emit_data.last_result = last_page;
            if (load) begin
               page_in = PW'(page_ff + PW'(1));
            end
         end
         ST_SRCH_PRD: pg_re = 1'b1;
         ST_SRCH_PCHK: begin
            slot_in  = '0;
            limit_in = count_lim;
            if (count_lim == '0) begin
               page_in = PW'(page_ff + PW'(1));
            end
         end
         ST_SRCH_KRD: key_re = 1'b1;
         ST_SRCH_KCHK: begin
            if (key_rdata == item_ff.record_key) begin
               if (!hit_ff) begin
                  hit_in      = 1'b1;
                  hit_page_in = page_ff;
                  hit_slot_in = slot_ff;
                  page_in     = PW'(page_ff + PW'(1));
               end
            end else if (last_slot) begin
               page_in = PW'(page_ff + PW'(1));
            end else begin
               slot_in = SW'(slot_ff + SW'(1));
            end
         end
         ST_SRCH_PUSH: begin
            // earlier hit goes out, current match becomes the pending one
            emit                  = 1'b1;
            emit_data.result_kind = KIND_HIT;
            emit_data.page_index  = hpage_wide[3:0];
            emit_data.slot_index  = hslot_wide[5:0];
            if (load) begin
               hit_page_in = page_ff;
               hit_slot_in = slot_ff;
               page_in     = PW'(page_ff + PW'(1));
            end
         end
         ST_SRCH_END: begin
            emit                  = 1'b1;
            emit_data.last_result = 1'b1;
            if (hit_ff) begin
               emit_data.result_kind = KIND_HIT;
               emit_data.page_index  = hpage_wide[3:0];
               emit_data.slot_index  = hslot_wide[5:0];
            end else begin
               emit_data.result_kind = KIND_MISS;
            end
         end
         default: ;
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_in       = load ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pages_open_ff <= '0;
         page_bytes_ff <= PAGE_BYTES_RESET;
         rsp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pages_open_ff <= pages_open_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_ff        <= hit_in;
         if (csr_we) begin
            page_bytes_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      page_ff     <= page_in;
      slot_ff     <= slot_in;
      limit_ff    <= limit_in;
      hit_page_ff <= hit_page_in;
      hit_slot_ff <= hit_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- bench/slotted_page_record_allocator_chk.sv -----
// Checker for the slotted page record allocator: predicts results from
// accepted request transactions and compares response transactions.
// Depends on spra_pkg.
module slotted_page_record_allocator_chk (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  spra_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  spra_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import spra_pkg::*;

   localparam int NPAGES = 16;
   localparam int NSLOTS = 64;

   logic [15:0] cap_bytes;
   int          open_pages;
   int          used_bytes [NPAGES];
   int          rec_count [NPAGES];
   logic [30:0] keys [NPAGES*NSLOTS];
   rsp_type     rsp_queue [$];

   function automatic rsp_type mk(logic [2:0] k, int pg, int sl, int cnt, bit lst);
      rsp_type r;
      r.result_kind = k;
      r.page_index  = pg[3:0];
      r.slot_index  = sl[5:0];
      r.count_value = cnt[6:0];
      r.last_result = lst;
      return r;
   endfunction

   // append one predicted response
   function automatic void queue_rsp(rsp_type r);
      rsp_queue = {rsp_queue, r};
   endfunction

   task automatic predict_action(req_type t);
      int p, s, need, freeb, n;
      need = int'(t.record_bytes) + 4;
      case (t.action)
         ACT_INSERT: begin
            for (p = 0; p < open_pages; p++) begin
               freeb = int'(cap_bytes) - used_bytes[p];
               if (freeb >= need) break;
            end
            if (p < open_pages) begin
               if (rec_count[p] >= NSLOTS) queue_rsp(mk(KIND_FULL, 0, 0, 0, 1'b1));
               else begin
                  keys[p*NSLOTS + rec_count[p]] = t.record_key;
                  rec_count[p]++;
                  used_bytes[p] += need;
                  if (used_bytes[p] > 65535) used_bytes[p] = 65535;
               end
            end else if (open_pages >= NPAGES) begin
               queue_rsp(mk(KIND_FULL, 0, 0, 0, 1'b1));
            end else begin
               keys[open_pages*NSLOTS] = t.record_key;
               rec_count[open_pages] = 1;
               used_bytes[open_pages] = 16 + need;
               if (used_bytes[open_pages] > 65535) used_bytes[open_pages] = 65535;
               open_pages++;
            end
         end
         ACT_STATUS: begin
            queue_rsp(mk(KIND_PAGE_TOTAL, 0, 0, open_pages, open_pages == 0));
            for (p = 0; p < open_pages; p++)
               queue_rsp(mk(KIND_PAGE_COUNT, p, 0, rec_count[p], p + 1 == open_pages));
         end
         ACT_SEARCH: begin
            n = 0;
            for (p = 0; p < open_pages; p++)
               for (s = 0; s < rec_count[p]; s++)
                  if (keys[p*NSLOTS + s] == t.record_key) begin
                     queue_rsp(mk(KIND_HIT, p, s, 0, 1'b0));
                     n++;
                     break;
                  end
            if (n == 0) queue_rsp(mk(KIND_MISS, 0, 0, 0, 1'b1));
            else rsp_queue[$].last_result = 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cap_bytes  <= PAGE_BYTES_RESET;
         open_pages = 0;
         rsp_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) cap_bytes <= csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_action(req_data);
      end
      pending <= rsp_queue.size();
   end
endmodule

// ----- bench/slotted_page_record_allocator_tb.sv -----
// Top of the allocator testbench: clock, reset, stimulus, verdict.
// Depends on spra_pkg, the allocator RTL and slotted_page_record_allocator_chk.
module slotted_page_record_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spra_pkg::*;

   // action code with no defined behavior
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending;

   // random sink stalls; long hold-off when requested; none in the tail
   bit sink_quiet = 0;
   bit sink_hold  = 0;
   int idle_cycles = 0;
   int key_pool [8];

   always #1 clock = ~clock;

   slotted_page_record_allocator dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_wdata
   );

   slotted_page_record_allocator_chk chk (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_wdata,
      .fail_count, .pending
   );

   // Watchdog: ends the run with FAIL when no request or response is taken; sink stalls stretch each result.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
         $display("slotted_page_record_allocator_tb: FAIL");
         $finish;
      end
   end

   // Sink process: bursts of stall, or a long counted hold-off on request.
   initial begin : sink
      int n, k;
      @(negedge reset);
      forever begin
         if (sink_hold) begin
            @(posedge clock) rsp_ready <= 0;
            for (k = 0; k < 3000; k++) @(posedge clock);
            sink_hold = 0;
         end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            @(posedge clock) rsp_ready <= 0;
            repeat (n - 1) @(posedge clock);
         end else begin
            @(posedge clock) rsp_ready <= 1;
         end
      end
   end

   // One request transaction; optional idle burst before it.
   task automatic send(logic [1:0] act, logic [15:0] size, logic [30:0] key, bit gaps);
      if (gaps && $urandom_range(0, 4) == 0) begin
         @(posedge clock) req_valid <= 0;
         repeat ($urandom_range(0, 14)) @(posedge clock);
      end
      @(posedge clock);
      req_valid <= 1;
      req_data  <= '{action: act, record_bytes: size, record_key: key};
      do @(posedge clock); while (!(req_valid && req_ready));
      req_valid <= 0;
   endtask

   // Wait for every expected result, then let a search-sized latency pass
   // so an insert still in flight has finished.
   task automatic drain();
      @(posedge clock) req_valid <= 0;
      repeat (4) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2200) @(posedge clock);
   endtask

   task automatic set_capacity(logic [15:0] v);
      drain();
      @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock) csr_we <= 0;
   endtask

   task automatic random_phase(int count, bit gaps);
      int i, r;
      logic [15:0] sz;
      logic [30:0] key;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 19);
         key = ($urandom_range(0, 1)) ? 31'(key_pool[$urandom_range(0, 7)])
                                       : 31'($urandom);
         sz = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
         if (r < 11) send(ACT_INSERT, sz, key, gaps);
         else if (r < 14) send(ACT_STATUS, 16'($urandom), key, gaps);
         else if (r < 19) send(ACT_SEARCH, 16'($urandom), key, gaps);
         else send(ACT_UNKNOWN, 16'($urandom), key, gaps);
      end
   endtask

   initial begin : stim
      int i;
      for (i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 0;
      key_pool[1] = 32'h7fffffff;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed: empty state, extremes, overfill, unknown action.
      send(ACT_STATUS, 16'd0, 31'd0, 1'b0);
      send(ACT_SEARCH, 16'd0, 31'd0, 1'b0);
      send(ACT_INSERT, 16'd0, 31'd0, 1'b0);
      send(ACT_INSERT, 16'hffff, 31'h7fffffff, 1'b0);
      send(ACT_INSERT, 16'd4076, 31'h7fffffff, 1'b0);
      send(ACT_INSERT, 16'd4075, 31'h1234, 1'b0);
      send(ACT_SEARCH, 16'd0, 31'h7fffffff, 1'b0);
      send(ACT_SEARCH, 16'd0, 31'h1235, 1'b0);
      send(ACT_UNKNOWN, 16'hffff, 31'h7fffffff, 1'b0);
      send(ACT_STATUS, 16'd0, 31'd0, 1'b0);

      // Slots run out: capacity max, 64 small records fill page 0.
      set_capacity(16'hffff);
      for (i = 0; i < 66; i++) send(ACT_INSERT, 16'd0, 31'(i), 1'b1);
      send(ACT_SEARCH, 16'd0, 31'd63, 1'b0);
      send(ACT_STATUS, 16'd0, 31'd0, 1'b0);
      send(ACT_SEARCH, 16'd0, 31'd63, 1'b0);

      // Pages run out: zero capacity, each insert opens a page until all are open.
      set_capacity(16'd0);
      for (i = 0; i < 14; i++) send(ACT_INSERT, 16'($urandom), 31'(key_pool[i % 8]), 1'b1);
      send(ACT_STATUS, 16'd0, 31'd0, 1'b0);

      // Long sink hold-off while requests keep coming, then sender pause.
      sink_hold = 1;
      random_phase(20, 1'b0);
      drain();

      set_capacity(16'd4096);
      random_phase(140, 1'b1);
      set_capacity(16'd300);
      random_phase(120, 1'b1);
      set_capacity(16'd0);
      random_phase(30, 1'b1);
      set_capacity(16'd1000);
      sink_quiet = 1;
      random_phase(60, 1'b0);

      drain();
      if (fail_count == 0)
         $display("slotted_page_record_allocator_tb: PASS");
      else
         $display("slotted_page_record_allocator_tb: FAIL");
      $finish;
   end
endmodule
